// ----- sv/lsbsd_pkg.sv -----
// ----------------------------------------------------------------------------
// lsbsd_pkg
// Shared types and constants for the LSB stego stream decoder.
// ----------------------------------------------------------------------------
package lsbsd_pkg;

  // Upper bound on the number of magic characters checked
  localparam int MAGIC_MAX_CHARS = 8;

  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SKIP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_CHARS = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0]  HEADER_SKIP_RST = 8'd54;
  localparam logic [3:0]  MAGIC_LEN_RST   = 4'd2;
  localparam logic [63:0] MAGIC_CHARS_RST = 64'h2A23;

  typedef enum logic [1:0] {
    KIND_EXT      = 2'd0,
    KIND_PAYLOAD  = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0]  header_skip;
    logic [3:0]  magic_len;
    logic [63:0] magic_chars;
  } cfg_t;

  // One registered input item; only bit 0 of the image byte carries data
  typedef struct packed {
    logic valid;
    logic data_bit;
    logic start;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } res_t;

endpackage

// ----- sv/lsbsd_cfg.sv -----
// ----------------------------------------------------------------------------
// lsbsd_cfg
// Configuration register file: header skip, magic length and magic chars.
// ----------------------------------------------------------------------------
module lsbsd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lsbsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  output lsbsd_pkg::cfg_t               cfg
);

  lsbsd_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_skip <= lsbsd_pkg::HEADER_SKIP_RST;
      cfg_r.magic_len   <= lsbsd_pkg::MAGIC_LEN_RST;
      cfg_r.magic_chars <= lsbsd_pkg::MAGIC_CHARS_RST;
    end else if (cfg_valid) begin
      // an index beyond the register list is dropped
      unique case (cfg_index)
        lsbsd_pkg::CFG_HEADER_SKIP: cfg_r.header_skip <= cfg_data[7:0];
        lsbsd_pkg::CFG_MAGIC_LEN:   cfg_r.magic_len   <= cfg_data[3:0];
        lsbsd_pkg::CFG_MAGIC_CHARS: cfg_r.magic_chars <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/lsbsd_core.sv -----
// ----------------------------------------------------------------------------
// lsbsd_core
// Decode state machine and result register; one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module lsbsd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  lsbsd_pkg::cfg_t   cfg,
  input  lsbsd_pkg::item_t  item,
  output logic              consume,
  output logic              res_valid_o,
  input  logic              res_ready,
  output lsbsd_pkg::res_t   res_o
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SKIP    = 3'd1,
    PH_MAGIC   = 3'd2,
    PH_EXTSIZE = 3'd3,
    PH_EXT     = 3'd4,
    PH_PSIZE   = 3'd5,
    PH_DATA    = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [3:0]  midx_r, midx_nxt;
  logic        good_r, good_nxt;

  logic             out_valid_r, out_valid_nxt;
  lsbsd_pkg::res_t  out_r;
  lsbsd_pkg::res_t  res;
  logic             res_valid;
  logic             advance;

  // state as seen by this byte once a start flag is applied
  phase_t      base_phase;
  logic [7:0]  base_skip;
  logic [4:0]  base_bit;
  logic [31:0] base_shift;
  logic [31:0] base_rem;
  logic [3:0]  base_midx;
  logic        base_good;

  phase_t      work_phase;
  logic [3:0]  magic_eff;
  logic        skip_lt;
  logic        wide;
  logic [31:0] shift_acc;
  logic [4:0]  bit_inc;
  logic        word_done;
  logic [3:0]  midx_inc;
  logic        magic_hit;
  logic        size_pos;
  logic [31:0] rem_dec;
  logic        rem_zero;

  assign advance = !out_valid_r || res_ready;
  assign consume = item.valid && advance;

  assign base_phase = item.start ? PH_SKIP : phase_r;
  assign base_skip  = item.start ? 8'd0    : skip_r;
  assign base_bit   = item.start ? 5'd0    : bit_r;
  assign base_shift = item.start ? 32'd0   : shift_r;
  assign base_rem   = item.start ? 32'd0   : rem_r;
  assign base_midx  = item.start ? 4'd0    : midx_r;
  assign base_good  = item.start ? 1'b1    : good_r;

  assign magic_eff = (cfg.magic_len > 4'(lsbsd_pkg::MAGIC_MAX_CHARS))
                     ? 4'(lsbsd_pkg::MAGIC_MAX_CHARS) : cfg.magic_len;
  assign skip_lt   = base_skip < cfg.header_skip;

  // skip ends into magic; an exhausted (or empty) magic falls through to size
  always_comb begin
    work_phase = (base_phase == PH_SKIP) ? PH_MAGIC : base_phase;
    if (work_phase == PH_MAGIC && base_midx >= magic_eff) begin
      work_phase = PH_EXTSIZE;
    end
  end

  assign wide      = (work_phase == PH_EXTSIZE) || (work_phase == PH_PSIZE);
  assign shift_acc = base_shift | (32'(item.data_bit) << base_bit);
  assign bit_inc   = base_bit + 5'd1;
  assign word_done = wide ? (bit_inc == 5'd0) : (bit_inc >= 5'd8);
  assign midx_inc  = base_midx + 4'd1;
  assign magic_hit = cfg.magic_chars[{base_midx[2:0], 3'b000} +: 8] == shift_acc[7:0];
  assign size_pos  = (shift_acc != 32'd0) && !shift_acc[31];
  assign rem_dec   = base_rem - 32'd1;
  assign rem_zero  = rem_dec == 32'd0;

  always_comb begin
    phase_nxt = base_phase;
    skip_nxt  = base_skip;
    bit_nxt   = base_bit;
    shift_nxt = base_shift;
    rem_nxt   = base_rem;
    midx_nxt  = base_midx;
    good_nxt  = base_good;
    res_valid = 1'b0;
    res.kind  = lsbsd_pkg::KIND_EXT;
    res.value = 8'd0;
    res.last  = 1'b0;
    if (base_phase == PH_SKIP && skip_lt) begin
      skip_nxt = base_skip + 8'd1;
    end else if (base_phase != PH_IDLE && base_phase != PH_DONE) begin
      phase_nxt = work_phase;
      if (!word_done) begin
        shift_nxt = shift_acc;
        bit_nxt   = bit_inc;
      end else begin
        shift_nxt = 32'd0;
        bit_nxt   = 5'd0;
        unique case (work_phase)
          PH_MAGIC: begin
            midx_nxt = midx_inc;
            good_nxt = base_good && magic_hit;
            if (midx_inc >= magic_eff) begin
              if (!good_nxt) begin
                phase_nxt = PH_DONE;
                res_valid = 1'b1;
                res.kind  = lsbsd_pkg::KIND_MISMATCH;
                res.last  = 1'b1;
              end else begin
                phase_nxt = PH_EXTSIZE;
              end
            end
          end
          PH_EXTSIZE: begin
            if (size_pos) begin
              rem_nxt   = shift_acc;
              phase_nxt = PH_EXT;
            end else begin
              phase_nxt = PH_PSIZE;
            end
          end
          PH_EXT: begin
            rem_nxt = rem_dec;
            if (rem_zero) begin
              phase_nxt = PH_PSIZE;
            end
            res_valid = 1'b1;
            res.kind  = lsbsd_pkg::KIND_EXT;
            res.value = shift_acc[7:0];
          end
          PH_PSIZE: begin
            if (size_pos) begin
              rem_nxt   = shift_acc;
              phase_nxt = PH_DATA;
            end else begin
              phase_nxt = PH_DONE;
              res_valid = 1'b1;
              res.kind  = lsbsd_pkg::KIND_EMPTY;
              res.last  = 1'b1;
            end
          end
          PH_DATA: begin
            rem_nxt = rem_dec;
            if (rem_zero) begin
              phase_nxt = PH_DONE;
            end
            res_valid = 1'b1;
            res.kind  = lsbsd_pkg::KIND_PAYLOAD;
            res.value = shift_acc[7:0];
            res.last  = rem_zero;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_nxt = advance ? (consume && res_valid) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      skip_r      <= 8'd0;
      bit_r       <= 5'd0;
      shift_r     <= 32'd0;
      rem_r       <= 32'd0;
      midx_r      <= 4'd0;
      good_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (consume) begin
        phase_r <= phase_nxt;
        skip_r  <= skip_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        rem_r   <= rem_nxt;
        midx_r  <= midx_nxt;
        good_r  <= good_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && res_valid) begin
      out_r <= res;
    end
  end

  assign res_valid_o = out_valid_r;
  assign res_o       = out_r;

  // a result that closes the stream leaves the decoder finished
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && res_valid && res.last) |=> (phase_r == PH_DONE))
    else $error("closing result did not leave decoder finished");

  a_ext_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == lsbsd_pkg::KIND_EXT) |-> !out_r.last)
    else $error("extension character marked last");

  a_narrow_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_EXTSIZE && phase_r != PH_PSIZE) |-> (bit_r < 5'd8))
    else $error("bit index past a character");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA || phase_r == PH_EXT) |-> (rem_r != 32'd0))
    else $error("payload phase with nothing remaining");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && base_phase == PH_IDLE) |-> !res_valid)
    else $error("result produced while idle");

endmodule

// ----- sv/lsb_stego_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// lsb_stego_stream_decoder_unit
// Recovers LSB-hidden magic, extension and payload from a stego image stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one image byte per transfer; in_tuser flags the first byte of a
//            file and restarts decoding with that byte as file byte 0.
//   out_*  : extension chars (kind 0), payload bytes (kind 1), magic mismatch
//            (kind 2), empty-payload done (kind 3); tlast on the final payload
//            byte, a mismatch and an empty-done.
//   cfg_*  : register writes (0 header skip, 1 magic length, 2 magic chars),
//            always ready; write only while the stream is idle.
// One byte per cycle unless a receiver stall holds it: input register,
// single-pass decode, result register. A result passes the input register
// and then the result register before it shows on out_*.
// On a receiver stall the result register holds, one more byte waits in the
// input register and in_tready then drops.
// After reset the decoder is idle until a start flag, registers 54 / 2 / "#*";
// bytes after completion or a mismatch are dropped until the next start flag.
// ----------------------------------------------------------------------------
module lsb_stego_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] image_byte
  input  logic [0:0]  in_tuser,   // [0] start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] value
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lsbsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  lsbsd_pkg::cfg_t  cfg;
  lsbsd_pkg::item_t item_r;
  lsbsd_pkg::res_t  res;
  logic             consume;
  logic             res_valid;

  lsbsd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_tready = !item_r.valid || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (in_tready) begin
      item_r.valid <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      item_r.data_bit <= in_tdata[0];
      item_r.start    <= in_tuser[0];
    end
  end

  lsbsd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .item        (item_r),
    .consume     (consume),
    .res_valid_o (res_valid),
    .res_ready   (out_tready),
    .res_o       (res)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = res.value;
  assign out_tuser  = res.kind;
  assign out_tlast  = res.last;

endmodule
